FILE: rtl/core/b2da_pkg.sv
package b2da_pkg;

  // Format codes
  localparam logic [1:0] OP_S8   = 2'd0;
  localparam logic [1:0] OP_U16  = 2'd1;
  localparam logic [1:0] OP_S32  = 2'd2;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] raw_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } out_beat_t;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_digits_t;

  // Classified job: sign and unsigned magnitude
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  // Converted number: BCD digits and index of leading digit
  typedef struct packed {
    logic                 neg;
    bcd_digits_t          digits;
    logic [DIG_IDX_W-1:0] top;
  } conv_res_t;

  // One double-dabble step: add 3 to nibbles >= 5, then shift in one bit
  function automatic bcd_digits_t dabble(bcd_digits_t d, logic b);
    bcd_digits_t                adj;
    logic [NUM_DIGITS*4-1:0]    flat;
    adj = d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[i] >= 4'd5) adj[i] = adj[i] + 4'd3;
    end
    flat = adj;
    flat = {flat[NUM_DIGITS*4-2:0], b};
    return flat;
  endfunction

endpackage

FILE: rtl/core/b2da_front.sv
module b2da_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  b2da_pkg::in_beat_t in_beat,
  output logic              push_valid,
  input  logic              push_ready,
  output b2da_pkg::job_t    push_job
);
  import b2da_pkg::*;

  logic               known;
  logic               neg;
  logic [VALUE_W-1:0] sext;

  // Sign-extend to 32 bits, then one shared negator gives the magnitude
  always_comb begin
    known = 1'b1;
    neg   = 1'b0;
    sext  = '0;
    case (in_beat.op)
      OP_S8: begin
        sext = {{(VALUE_W-8){in_beat.raw_value[7]}}, in_beat.raw_value[7:0]};
        neg  = in_beat.raw_value[7];
      end
      OP_U16: begin
        sext = {{(VALUE_W-16){1'b0}}, in_beat.raw_value[15:0]};
      end
      OP_S32: begin
        sext = in_beat.raw_value;
        neg  = in_beat.raw_value[VALUE_W-1];
      end
      default: known = 1'b0;  // unused format: dropped
    endcase
  end

  assign push_job.neg = neg;
  assign push_job.mag = neg ? (VALUE_W'(0) - sext) : sext;
  assign push_valid   = in_valid && known;
  assign in_ready     = push_ready;

endmodule

FILE: rtl/core/b2da_queue.sv
module b2da_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  b2da_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output b2da_pkg::job_t rd_job
);
  import b2da_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

FILE: rtl/core/b2da_conv.sv
module b2da_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  b2da_pkg::job_t      job,
  output logic                res_valid,
  input  logic                res_ready,
  output b2da_pkg::conv_res_t res
);
  import b2da_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  full_r, full_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]    sh_r, sh_nxt;
  bcd_digits_t           bcd_r, bcd_nxt;
  logic                  neg_r, neg_nxt;
  bcd_digits_t           stepped;
  logic                  load;
  logic [DIG_IDX_W-1:0]  top;

  assign job_ready = !busy_r && (!full_r || res_ready);
  assign load      = job_valid && job_ready;

  // Four dabble steps per cycle on the top bits of the shifter
  always_comb begin
    stepped = bcd_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      stepped = dabble(stepped, sh_r[VALUE_W-1-k]);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    full_nxt = full_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (full_r && res_ready) full_nxt = 1'b0;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = job.mag;
      bcd_nxt  = '0;
      neg_nxt  = job.neg;
    end else if (busy_r) begin
      sh_nxt  = sh_r << BITS_PER_STEP;
      bcd_nxt = stepped;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_CNT_W'(CONV_STEPS-1)) begin
        busy_nxt = 1'b0;
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      full_r <= full_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  // Leading digit: highest nonzero nibble, digit 0 for zero
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) top = DIG_IDX_W'(i);
    end
  end

  assign res_valid  = full_r;
  assign res.neg    = neg_r;
  assign res.digits = bcd_r;
  assign res.top    = top;

endmodule

FILE: rtl/core/b2da_emit.sv
module b2da_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  b2da_pkg::conv_res_t  res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b2da_pkg::out_beat_t  out_beat
);
  import b2da_pkg::*;

  logic                 active_r, active_nxt;
  logic                 sign_r, sign_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  bcd_digits_t          digits_r, digits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_beat_r, out_beat_nxt;
  logic                 take, load;

  assign res_ready = !active_r;
  assign take      = res_valid && res_ready;
  assign load      = active_r && (!out_valid_r || out_ready);

  always_comb begin
    active_nxt    = active_r;
    sign_nxt      = sign_r;
    idx_nxt       = idx_r;
    digits_nxt    = digits_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (take) begin
      active_nxt = 1'b1;
      sign_nxt   = res.neg;
      idx_nxt    = res.top;
      digits_nxt = res.digits;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      if (sign_r) begin
        out_beat_nxt.ascii_char = CHAR_MINUS;
        out_beat_nxt.last       = 1'b0;
        sign_nxt                = 1'b0;
      end else begin
        out_beat_nxt.ascii_char = CHAR_ZERO | {4'd0, digits_r[idx_r]};
        out_beat_nxt.last       = (idx_r == '0);
        if (idx_r == '0) active_nxt = 1'b0;
        else             idx_nxt    = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r     <= sign_nxt;
    idx_r      <= idx_nxt;
    digits_r   <= digits_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: rtl/core/binary_to_decimal_ascii_core.sv
// channel | dir | handshake             | payload
// --------+-----+-----------------------+------------------------------------
// in_     | in  | in_valid / in_ready   | in_beat: op, raw_value (one number)
// out_    | out | out_valid / out_ready | out_beat: ascii_char, last (1 char)
//
// Flow: one beat per character; conversion loads the magnitude, then shifts it
// through the BCD shifter at 4 bits per cycle, taking no new number meanwhile;
// characters then leave one per cycle while out_ready is high, and the emitter
// takes the next number only after the last character of the one before is loaded.
// Reset clears all handshake state; no clearing pass. A stall on out_ holds the
// output register; up to two numbers queue ahead.
module binary_to_decimal_ascii_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b2da_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output b2da_pkg::out_beat_t out_beat
);
  import b2da_pkg::*;

  // front -> queue
  logic      push_valid, push_ready;
  job_t      push_job;
  // queue -> converter
  logic      job_valid, job_ready;
  job_t      job;
  // converter -> emitter
  logic      res_valid, res_ready;
  conv_res_t res;

  // Classify format, take sign and magnitude; unused format is dropped
  b2da_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Short queue decoupling intake from conversion
  b2da_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_job   (push_job),
    .rd_valid (job_valid),
    .rd_ready (job_ready),
    .rd_job   (job)
  );

  // Double dabble, result held until the emitter takes it
  b2da_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Sign, then digits from the leading one down, into the output register
  b2da_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.ascii_char == CHAR_MINUS) |-> !out_beat.last)
    else $error("minus sign flagged as last");

  // Only digits or a minus sign leave
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_beat.ascii_char >= CHAR_ZERO && out_beat.ascii_char <= CHAR_NINE)
                   || out_beat.ascii_char == CHAR_MINUS))
    else $error("character outside digit and minus set");

  // Converter is busy right after it takes a job
  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> !job_ready)
    else $error("converter took a job while busy");

  // Emitter is busy right after it takes a converted number
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> !res_ready)
    else $error("emitter took a number while busy");

endmodule
